[src/sgb_pkg.sv]
`default_nettype none
package sgb_pkg;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_RADIUS = 7;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int WIN_DEPTH  = 2 * MAX_RADIUS + 1;
	localparam int NUM_BANKS  = 2 * MAX_RADIUS;
	localparam int PIX_W      = 8;
	localparam int WT_W       = 16;
	localparam int PROD_W     = PIX_W + WT_W;

	localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [2:0] REG_BLUR_RADIUS  = 3'd2;
	localparam logic [2:0] REG_WEIGHTS_NEAR = 3'd3;
	localparam logic [2:0] REG_WEIGHTS_FAR  = 3'd4;

	// Weight for tap offset 0..7, picked out of the two packed weight words.
	function automatic logic [WT_W-1:0] tap_weight(input logic [63:0] near,
			input logic [63:0] far, input logic [2:0] off);
		logic [63:0] src;
		src = off[2] ? far : near;
		case (off[1:0])
			2'd0: tap_weight = src[15:0];
			2'd1: tap_weight = src[31:16];
			2'd2: tap_weight = src[47:32];
			2'd3: tap_weight = src[63:48];
			default: tap_weight = '0;
		endcase
	endfunction
endpackage
`default_nettype wire

[src/separable_gaussian_blur.sv]
`default_nettype none
// Separable Gaussian blur, one 8-bit grayscale pixel per clock in and out when not stalled.
// Feed (height+radius) rows of (width+radius) pixels; positions outside the frame are
// ignored. Each accepted word runs through a registered pipeline: a row of 15 window cells
// forms the horizontal sum, and 14 line-store banks of 1024 x 8 (one per stored row)
// supply the column for the vertical sum. A 16-word output queue absorbs stalls, so the
// input keeps flowing while results wait, until 16 words are outstanding.
// The line stores need no clearing after reset.
// Registers are 64-bit at byte offsets 0, 8, 16, 24, 32; write them only while idle.
module separable_gaussian_blur import sgb_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready,
	input  wire logic        src_valid,
	output logic             src_ready,
	input  wire logic [7:0]  pixel_in,
	output logic             dst_valid,
	input  wire logic        dst_ready,
	output logic      [7:0]  pixel_out,
	output logic             frame_end
);
	localparam int QDEPTH = 16;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef struct packed {
		logic              emit;
		logic              hv;
		logic              last;
		logic [ADDR_W-1:0] col;
		logic [12:0]       row;
		logic [3:0]        imod;
	} meta_t;

	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [2:0]  radius_q;
	logic [63:0] near_q;
	logic [63:0] far_q;

	logic [10:0] w_eff, ew, col_cur, col_nxt;
	logic [12:0] h_eff, eh, row_cur, row_nxt;
	logic [3:0]  imod_cur, imod_nxt, span;
	logic [10:0] col_q;
	logic [12:0] row_q;
	logic [3:0]  imod_q;
	logic        accept;
	logic [7:0]  px;
	meta_t       meta_in;

	meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5, meta_s6, meta_s7;
	logic  v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic [PIX_W-1:0]  win [WIN_DEPTH];
	logic [PROD_W-1:0] hprod [WIN_DEPTH];
	logic [WT_W-1:0]   hwt [WIN_DEPTH];
	logic [PROD_W-1:0] vprod [NUM_BANKS];
	logic [PROD_W-1:0] cprod_s6;
	logic [25:0]       hgrp_s3 [4];
	logic [25:0]       vgrp_s7 [4];
	logic [25:0]       hgrp_d [4];
	logic [25:0]       vgrp_d [4];
	logic [27:0]       htot, vtot;
	logic [7:0]        hval_d, hval_s4, hval_s5, vval;
	logic              store_we;

	logic [8:0]        fifo_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   fcnt_q, occ_q;
	logic              push, drop, pop;

	// Configuration port.
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd64;
			height_q <= 13'd64;
			radius_q <= 3'd1;
			near_q   <= 64'h0000_0000_4000_8000;
			far_q    <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[5:3])
				REG_FRAME_WIDTH:  width_q  <= pwdata[10:0];
				REG_FRAME_HEIGHT: height_q <= pwdata[12:0];
				REG_BLUR_RADIUS:  radius_q <= pwdata[2:0];
				REG_WEIGHTS_NEAR: near_q   <= pwdata;
				REG_WEIGHTS_FAR:  far_q    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[5:3])
			REG_FRAME_WIDTH:  prdata = {53'd0, width_q};
			REG_FRAME_HEIGHT: prdata = {51'd0, height_q};
			REG_BLUR_RADIUS:  prdata = {61'd0, radius_q};
			REG_WEIGHTS_NEAR: prdata = near_q;
			REG_WEIGHTS_FAR:  prdata = far_q;
			default:          prdata = '0;
		endcase
	end

	// Raster position.
	always_comb begin
		w_eff = width_q;
		if (width_q == 11'd0) w_eff = 11'd1;
		if (width_q > 11'(MAX_WIDTH)) w_eff = 11'(MAX_WIDTH);
		h_eff = height_q;
		if (height_q == 13'd0) h_eff = 13'd1;
		if (height_q > 13'd4096) h_eff = 13'd4096;
		ew   = w_eff + {8'd0, radius_q};
		eh   = h_eff + {10'd0, radius_q};
		span = {radius_q, 1'b0};

		col_cur  = (col_q >= ew) ? 11'd0 : col_q;
		row_cur  = (row_q >= eh) ? 13'd0 : row_q;
		imod_cur = (row_q >= eh) ? 4'd0 : imod_q;

		col_nxt  = col_cur + 11'd1;
		row_nxt  = row_cur;
		imod_nxt = imod_cur;
		if (col_nxt >= ew) begin
			col_nxt = 11'd0;
			if (row_cur + 13'd1 >= eh) begin
				row_nxt  = 13'd0;
				imod_nxt = 4'd0;
			end else begin
				row_nxt  = row_cur + 13'd1;
				imod_nxt = (imod_cur + 4'd1 == span) ? 4'd0 : imod_cur + 4'd1;
			end
		end

		px = (row_cur < h_eff && col_cur < w_eff) ? pixel_in : 8'd0;

		meta_in.hv   = col_cur >= {8'd0, radius_q};
		meta_in.emit = meta_in.hv && (row_cur >= {10'd0, radius_q});
		meta_in.last = (row_cur == eh - 13'd1) && (col_cur == ew - 11'd1);
		meta_in.col  = ADDR_W'(col_cur - {8'd0, radius_q});
		meta_in.row  = row_cur;
		meta_in.imod = imod_cur;
	end

	assign accept    = src_valid && src_ready;
	assign src_ready = occ_q < (QPTR_W+1)'(QDEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			imod_q <= '0;
		end else if (accept) begin
			col_q  <= col_nxt;
			row_q  <= row_nxt;
			imod_q <= imod_nxt;
		end
	end

	// Pipeline bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			meta_s1 <= meta_in;
		end
		meta_s2 <= meta_s1;
		meta_s3 <= meta_s2;
		meta_s4 <= meta_s3;
		meta_s5 <= meta_s4;
		meta_s6 <= meta_s5;
		meta_s7 <= meta_s6;
	end

	// Horizontal pass: window cells shift on every accepted word.
	genvar gd;
	generate
		for (gd = 0; gd < WIN_DEPTH; gd++) begin : g_h
			logic [3:0] off;
			logic       on;
			always_comb begin
				off = (4'(gd) >= {1'b0, radius_q}) ? 4'(gd) - {1'b0, radius_q}
					: {1'b0, radius_q} - 4'(gd);
				on  = 4'(gd) <= span;
				hwt[gd] = on ? tap_weight(near_q, far_q, off[2:0]) : '0;
			end
			sgb_hcell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (accept),
				.clr    ((gd != 0) && (col_cur == 11'd0)),
				.din    ((gd == 0) ? px : win[(gd == 0) ? 0 : gd - 1]),
				.weight (hwt[gd]),
				.tap    (win[gd]),
				.prod   (hprod[gd])
			);
		end
	endgenerate

	always_comb begin
		for (int g = 0; g < 4; g++) begin
			hgrp_d[g] = '0;
			vgrp_d[g] = '0;
			for (int k = 0; k < 4; k++) begin
				if (4 * g + k < WIN_DEPTH) begin
					hgrp_d[g] = hgrp_d[g] + 26'(hprod[4 * g + k]);
				end
				if (4 * g + k < NUM_BANKS) begin
					vgrp_d[g] = vgrp_d[g] + 26'(vprod[4 * g + k]);
				end
			end
		end
		// The center row comes straight from the horizontal pass.
		vgrp_d[3] = vgrp_d[3] + 26'(cprod_s6);
	end

	always_comb begin
		htot   = 28'(hgrp_s3[0]) + 28'(hgrp_s3[1]) + 28'(hgrp_s3[2]) + 28'(hgrp_s3[3]);
		hval_d = (htot[27:16] > 12'd255) ? 8'd255 : htot[23:16];
		vtot   = 28'(vgrp_s7[0]) + 28'(vgrp_s7[1]) + 28'(vgrp_s7[2]) + 28'(vgrp_s7[3]);
		vval   = (vtot[27:16] > 12'd255) ? 8'd255 : vtot[23:16];
	end

	always_ff @(posedge clk) begin
		hgrp_s3  <= hgrp_d;
		hval_s4  <= hval_d;
		hval_s5  <= hval_s4;
		cprod_s6 <= PROD_W'(hval_s5) * PROD_W'(tap_weight(near_q, far_q, radius_q));
		vgrp_s7  <= vgrp_d;
	end

	// Vertical pass: each bank holds one stored row, written at slot row mod 2r.
	assign store_we = v_s4 && meta_s4.hv && (radius_q != 3'd0);

	genvar gb;
	generate
		for (gb = 0; gb < NUM_BANKS; gb++) begin : g_v
			sgb_vcell u_cell (
				.clk      (clk),
				.bank_idx (4'(gb)),
				.we       (store_we && (meta_s4.imod == 4'(gb))),
				.addr     (meta_s4.col),
				.wdata    (hval_s4),
				.imod     (meta_s5.imod),
				.row      (meta_s5.row),
				.radius   (radius_q),
				.near     (near_q),
				.far      (far_q),
				.prod     (vprod[gb])
			);
		end
	endgenerate

	// Output queue with occupancy credit covering words still in the pipeline.
	assign push = v_s7 && meta_s7.emit;
	assign drop = v_s7 && !meta_s7.emit;
	assign pop  = dst_valid && dst_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= {meta_s7.last, vval};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			fcnt_q <= '0;
			occ_q  <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			fcnt_q <= fcnt_q + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
			occ_q  <= occ_q + {{QPTR_W{1'b0}}, accept} - {{QPTR_W{1'b0}}, drop}
				- {{QPTR_W{1'b0}}, pop};
		end
	end

	assign dst_valid = fcnt_q != '0;
	assign pixel_out = fifo_q[rp_q][7:0];
	assign frame_end = fifo_q[rp_q][8];

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= (QPTR_W+1)'(QDEPTH))
		else $error("occupancy credit exceeds queue depth");

	a_queue_in_credit: assert property (@(posedge clk) disable iff (!arst_n)
		fcnt_q <= occ_q)
		else $error("queued words exceed outstanding credit");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (fcnt_q < (QPTR_W+1)'(QDEPTH)) || pop)
		else $error("output queue overflow");

	a_credit_return: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0) |-> !v_s7 && !dst_valid)
		else $error("word in flight without credit");
endmodule
`default_nettype wire

[src/sgb_hcell.sv]
`default_nettype none
module sgb_hcell import sgb_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              clr,
	input  wire logic [PIX_W-1:0]  din,
	input  wire logic [WT_W-1:0]   weight,
	output logic      [PIX_W-1:0]  tap,
	output logic      [PROD_W-1:0] prod
);
	logic [PIX_W-1:0]  tap_q;
	logic [PROD_W-1:0] prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (en) begin
			tap_q <= clr ? '0 : din;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(tap_q) * PROD_W'(weight);
	end

	assign tap  = tap_q;
	assign prod = prod_s2;
endmodule
`default_nettype wire

[src/sgb_vcell.sv]
`default_nettype none
module sgb_vcell import sgb_pkg::*; (
	input  wire logic              clk,
	input  wire logic [3:0]        bank_idx,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [PIX_W-1:0]  wdata,
	input  wire logic [3:0]        imod,
	input  wire logic [12:0]       row,
	input  wire logic [2:0]        radius,
	input  wire logic [63:0]       near,
	input  wire logic [63:0]       far,
	output logic      [PROD_W-1:0] prod
);
	logic [PIX_W-1:0]  mem [MAX_WIDTH];
	logic [PIX_W-1:0]  rdata_s5;
	logic [PROD_W-1:0] prod_s6;
	logic [3:0]        span;
	logic [4:0]        diff;
	logic [3:0]        row_back;
	logic [3:0]        off;
	logic              use_it;
	logic [WT_W-1:0]   wt;

	// Read returns the old contents when the same entry is written in this cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_s5 <= mem[addr];
	end

	// This bank holds row i-row_back, where row_back runs 1..2r.
	always_comb begin
		span = {radius, 1'b0};
		if (imod >= bank_idx) begin
			diff = {1'b0, imod} - {1'b0, bank_idx};
		end else begin
			diff = {1'b0, imod} + {1'b0, span} - {1'b0, bank_idx};
		end
		row_back = (diff == 5'd0) ? span : diff[3:0];
		use_it = (bank_idx < span) && (row >= {9'd0, row_back});
		off = (row_back >= {1'b0, radius}) ? row_back - {1'b0, radius}
			: {1'b0, radius} - row_back;
		wt = use_it ? tap_weight(near, far, off[2:0]) : '0;
	end

	// Unused banks and rows above the frame are masked, so unwritten entries never reach the sum.
	always_ff @(posedge clk) begin
		prod_s6 <= use_it ? PROD_W'(rdata_s5) * PROD_W'(wt) : '0;
	end

	assign prod = prod_s6;
endmodule
`default_nettype wire
